FILE: hdl/uers_pkg.sv
package uers_pkg;

	localparam int unsigned MaxTextBytes = 65536;
	localparam int unsigned PosW = 17;

	localparam logic [PosW-1:0] PosCap = PosW'(MaxTextBytes + 1);
	localparam logic [PosW-1:0] PosRep = PosW'(MaxTextBytes);

	localparam logic [20:0] CpZwj = 21'h200D;
	localparam logic [20:0] CpVs16 = 21'hFE0F;
	localparam logic [20:0] CpKeycap = 21'h20E3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [PosW-1:0] run_start;
		logic [PosW-1:0] run_end;
		logic            run_is_emoji;
		logic            run_final;
		logic            offset_overflow;
	} out_word_t;

	// codepoint events from the decoder to the run builder
	typedef struct packed {
		logic [3:0]      n_cp;
		logic [2:0][20:0] cp;
		logic [2:0][PosW-1:0] cp_end;
		logic            flush;
		logic            ovf;
	} cp_word_t;

	function automatic logic in_rng(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
		return c >= lo && c <= hi;
	endfunction

	function automatic logic is_cont(logic [20:0] c);
		return c == CpZwj || in_rng(c, 21'hFE00, 21'hFE0F) || c == CpKeycap ||
			in_rng(c, 21'h1F3FB, 21'h1F3FF);
	endfunction

	function automatic logic is_keycap_lead(logic [20:0] c);
		return in_rng(c, 21'h30, 21'h39) || c == 21'h2A || c == 21'h23;
	endfunction

	function automatic logic is_base(logic [20:0] c);
		return c == 21'hA9 || c == 21'hAE || c == 21'h203C || c == 21'h2049 ||
			c == 21'h2122 || c == 21'h2139 || in_rng(c, 21'h2194, 21'h2199) ||
			in_rng(c, 21'h21A9, 21'h21AA) || in_rng(c, 21'h231A, 21'h231B) ||
			c == 21'h2328 || c == 21'h23CF || in_rng(c, 21'h23E9, 21'h23FA) ||
			c == 21'h24C2 || in_rng(c, 21'h25AA, 21'h25FE) ||
			in_rng(c, 21'h2600, 21'h27BF) || in_rng(c, 21'h2934, 21'h2935) ||
			in_rng(c, 21'h2B05, 21'h2B55) || c == 21'h3030 || c == 21'h303D ||
			c == 21'h3297 || c == 21'h3299 || c == 21'h1F004 || c == 21'h1F0CF ||
			in_rng(c, 21'h1F170, 21'h1F171) || in_rng(c, 21'h1F17E, 21'h1F17F) ||
			c == 21'h1F18E || in_rng(c, 21'h1F191, 21'h1F19A) ||
			in_rng(c, 21'h1F1E0, 21'h1F1FF) || in_rng(c, 21'h1F201, 21'h1F251) ||
			in_rng(c, 21'h1F300, 21'h1F9FF) || in_rng(c, 21'h1FA00, 21'h1FAFF);
	endfunction

	function automatic logic [PosW-1:0] rep(logic [PosW-1:0] x);
		return (x > PosRep) ? PosRep : x;
	endfunction

endpackage

FILE: hdl/uers_front.sv
module uers_front import uers_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      q_valid,
	input  logic      q_stall,
	output cp_word_t  q_word
);

	logic [1:0]      need_q;
	logic [20:0]     part_q;
	logic [1:0]      cnt_q;
	logic [7:0]      held_q [3];
	logic [PosW-1:0] lead_q;
	logic [PosW-1:0] pos_q;
	logic            ov_valid_q;
	cp_word_t        ov_word_q;

	logic            acc;
	logic [PosW-1:0] pos_n;
	logic [7:0]      b;
	logic [7:0]      hb [3];
	logic [1:0]      hn;
	cp_word_t        w;
	logic [1:0]      need_n;
	logic [20:0]     part_n;
	logic [1:0]      cnt_n;
	logic            cut;

	assign in_stall = ov_valid_q && q_stall;
	assign acc = in_valid && !in_stall;
	assign q_valid = ov_valid_q;
	assign q_word = ov_word_q;
	assign b = in_word.text_byte;
	assign pos_n = (pos_q == PosCap) ? PosCap : pos_q + 1'b1;

	function automatic logic [PosW-1:0] lead_pos(logic [1:0] k);
		logic [PosW+1:0] s;
		s = {2'd0, ((need_q == 2'd0) ? pos_q : lead_q)} + {{PosW{1'b0}}, k};
		return (s > {2'd0, PosCap}) ? PosCap : s[PosW-1:0];
	endfunction

	always_comb begin
		w = '0;
		need_n = need_q;
		part_n = part_q;
		cnt_n = cnt_q;
		cut = 1'b0;
		hb[0] = held_q[0];
		hb[1] = held_q[1];
		hb[2] = held_q[2];
		hn = cnt_q;
		if (need_q == 2'd0) begin
			if (b[7:5] == 3'b110) begin
				need_n = 2'd1; part_n = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				need_n = 2'd2; part_n = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				need_n = 2'd3; part_n = {18'd0, b[2:0]};
			end
			if (need_n == 2'd0) begin
				w.n_cp = 4'd1;
				w.cp[0] = {13'd0, b};
				w.cp_end[0] = pos_n;
			end else begin
				hb[0] = b;
				hn = 2'd1;
				cnt_n = 2'd1;
				cut = in_word.last_byte;
			end
		end else begin
			part_n = {part_q[14:0], b[5:0]};
			if (cnt_q < 2'd3) hb[cnt_q] = b;
			hn = cnt_q + 2'd1;
			cnt_n = cnt_q + 2'd1;
			need_n = need_q - 2'd1;
			if (need_n == 2'd0) begin
				cnt_n = 2'd0;
				w.n_cp = 4'd1;
				w.cp[0] = part_n;
				w.cp_end[0] = pos_n;
			end else begin
				cut = in_word.last_byte;
			end
		end
		// re-decode held bytes of a cut-off sequence, at most three codepoints
		if (cut) begin
			if (hb[0][7:5] == 3'b110 && hn > 2'd1) begin
				w.cp[0] = {10'd0, hb[0][4:0], hb[1][5:0]};
				w.cp_end[0] = lead_pos(2'd2);
				w.cp[1] = {13'd0, hb[2]};
				w.cp_end[1] = lead_pos(2'd3);
				w.n_cp = (hn == 2'd3) ? 4'd2 : 4'd1;
			end else begin
				w.cp[0] = {13'd0, hb[0]};
				w.cp_end[0] = lead_pos(2'd1);
				if (hb[1][7:5] == 3'b110 && hn == 2'd3) begin
					w.cp[1] = {10'd0, hb[1][4:0], hb[2][5:0]};
					w.cp_end[1] = lead_pos(2'd3);
					w.n_cp = 4'd2;
				end else begin
					w.cp[1] = {13'd0, hb[1]};
					w.cp_end[1] = lead_pos(2'd2);
					w.cp[2] = {13'd0, hb[2]};
					w.cp_end[2] = lead_pos(2'd3);
					w.n_cp = {2'd0, hn};
				end
			end
		end
		w.flush = in_word.last_byte;
		w.ovf = (pos_n > PosRep);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= '0;
			part_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			ov_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				ov_valid_q <= 1'b1;
				if (in_word.last_byte) begin
					need_q <= '0;
					part_q <= '0;
					cnt_q <= '0;
					pos_q <= '0;
				end else begin
					need_q <= need_n;
					part_q <= part_n;
					cnt_q <= cnt_n;
					pos_q <= pos_n;
				end
			end else if (!q_stall) begin
				ov_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ov_word_q <= w;
			held_q <= hb;
			if (need_q == 2'd0) lead_q <= pos_q;
		end
	end

endmodule

FILE: hdl/uers_fifo.sv
module uers_fifo import uers_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_stall,
	input  cp_word_t wr_word,
	output logic     rd_valid,
	input  logic     rd_take,
	output cp_word_t rd_word
);

	cp_word_t  mem_q [4];
	logic [2:0] wp_q, rp_q;
	logic       full, empty;

	assign full = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
	assign empty = (wp_q == rp_q);
	assign wr_stall = full;
	assign rd_valid = !empty;
	assign rd_word = mem_q[rp_q[1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && !full) wp_q <= wp_q + 3'd1;
			if (rd_take && !empty) rp_q <= rp_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid && !full) mem_q[wp_q[1:0]] <= wr_word;
	end

endmodule

FILE: hdl/uers_back.sv
module uers_back import uers_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_take,
	input  cp_word_t  q_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	// working state of the run builder
	typedef struct packed {
		logic [PosW-1:0] rs;
		logic [PosW-1:0] re;
		logic            emo;
		logic            open;
		logic [1:0]      la;
		logic [PosW-1:0] lead_end;
		logic [PosW-1:0] sel_end;
	} rb_t;

	// one step: one codepoint, or the final flush
	typedef struct packed {
		rb_t        st;
		logic [1:0] n_emit;
		out_word_t  e0;
		out_word_t  e1;
	} step_t;

	rb_t        st_q;
	logic [3:0] idx_q;
	out_word_t  fifo_q [2];
	logic [1:0] cnt_q;
	logic       rp_q;

	step_t      sr;
	logic       last_step;
	logic       step_go;
	logic       room;

	function automatic out_word_t mk(logic [PosW-1:0] s, logic [PosW-1:0] e, logic emo,
		logic fin, logic ov);
		out_word_t o;
		o.run_start = rep(s);
		o.run_end = rep(e);
		o.run_is_emoji = emo;
		o.run_final = fin;
		o.offset_overflow = ov;
		return o;
	endfunction

	function automatic step_t add_item(step_t x, logic emo, logic [PosW-1:0] e, logic ov);
		step_t r;
		r = x;
		if (r.st.open && r.st.emo == emo) begin
			r.st.re = e;
		end else begin
			if (r.st.open) begin
				if (r.n_emit == 2'd0) r.e0 = mk(r.st.rs, r.st.re, r.st.emo, 1'b0, ov);
				else r.e1 = mk(r.st.rs, r.st.re, r.st.emo, 1'b0, ov);
				r.n_emit = r.n_emit + 2'd1;
				r.st.rs = r.st.re;
			end else begin
				r.st.rs = '0;
			end
			r.st.open = 1'b1;
			r.st.emo = emo;
			r.st.re = e;
		end
		return r;
	endfunction

	function automatic step_t add_cont(step_t x, logic [PosW-1:0] e);
		step_t r;
		r = x;
		if (!r.st.open) begin
			r.st.open = 1'b1;
			r.st.rs = '0;
			r.st.emo = 1'b0;
		end
		r.st.re = e;
		return r;
	endfunction

	logic [20:0]     c;
	logic [PosW-1:0] ce;
	logic            do_cp;

	always_comb begin
		sr = '0;
		sr.st = st_q;
		do_cp = (idx_q < q_word.n_cp);
		c = q_word.cp[idx_q[1:0]];
		ce = q_word.cp_end[idx_q[1:0]];
		if (do_cp) begin
			if (st_q.la == 2'd1 && c == CpVs16) begin
				sr.st.sel_end = ce;
				sr.st.la = 2'd2;
			end else if (st_q.la != 2'd0 && c == CpKeycap) begin
				sr = add_item(sr, 1'b1, ce, q_word.ovf);
				sr.st.la = 2'd0;
			end else begin
				if (st_q.la != 2'd0) begin
					sr = add_item(sr, 1'b0, st_q.lead_end, q_word.ovf);
					if (st_q.la == 2'd2) sr = add_cont(sr, st_q.sel_end);
					sr.st.la = 2'd0;
				end
				if (is_keycap_lead(c)) begin
					sr.st.lead_end = ce;
					sr.st.la = 2'd1;
				end else if (is_cont(c)) begin
					sr = add_cont(sr, ce);
				end else begin
					sr = add_item(sr, is_base(c), ce, q_word.ovf);
				end
			end
		end else begin
			if (st_q.la != 2'd0) begin
				sr = add_item(sr, 1'b0, st_q.lead_end, q_word.ovf);
				if (st_q.la == 2'd2) sr = add_cont(sr, st_q.sel_end);
			end
			if (sr.st.open) begin
				if (sr.n_emit == 2'd0)
					sr.e0 = mk(sr.st.rs, sr.st.re, sr.st.emo, 1'b1, q_word.ovf);
				else
					sr.e1 = mk(sr.st.rs, sr.st.re, sr.st.emo, 1'b1, q_word.ovf);
				sr.n_emit = sr.n_emit + 2'd1;
			end
			sr.st = '0;
		end
	end

	assign room = ({1'b0, cnt_q} + {1'b0, sr.n_emit}) <= 3'd2 + {2'd0, out_valid && !out_stall};
	assign last_step = q_word.flush ? !do_cp : (idx_q + 4'd1 >= q_word.n_cp);
	assign step_go = q_valid && room && (do_cp || q_word.flush);
	assign q_take = q_valid && (step_go ? last_step : (!do_cp && !q_word.flush));
	assign out_valid = (cnt_q != 2'd0);
	assign out_word = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			rp_q <= 1'b0;
		end else begin
			if (step_go) begin
				st_q <= sr.st;
				idx_q <= last_step ? 4'd0 : idx_q + 4'd1;
			end
			if (out_valid && !out_stall) rp_q <= ~rp_q;
			cnt_q <= cnt_q - {1'b0, out_valid && !out_stall} +
				(step_go ? sr.n_emit : 2'd0);
		end
	end

	logic wp;
	assign wp = rp_q ^ cnt_q[0];

	always_ff @(posedge clk) begin
		if (step_go && sr.n_emit != 2'd0) begin
			fifo_q[wp] <= sr.e0;
			if (sr.n_emit == 2'd2) fifo_q[~wp] <= sr.e1;
		end
	end

endmodule

FILE: hdl/utf8_emoji_run_segmenter.sv
// UTF-8 emoji run segmenter.
// Input channel (in_valid/in_stall/in_word): one text byte per word, with
// last_byte marking the final byte of a text. Output channel
// (out_valid/out_stall/out_word): one closed run per word, with its byte
// range, emoji flag, final flag and offset overflow flag.
// Front decodes UTF-8 and registers up to three codepoints per byte (three
// only when a text ends inside a multibyte sequence). A four-deep queue
// decouples it from the back end, which walks codepoints one per cycle,
// while its two-entry output buffer has room, through the keycap lookahead
// and run merge logic, writing runs into that buffer.
// Throughput: one byte per cycle unless the receiver stalls. The final byte
// of a text also needs a back-end flush step, plus a step per extra
// re-decoded codepoint of a cut-off tail; the queue absorbs these.
// After the byte that closes a run is taken, the run word is registered in
// the front register, then the queue, then the output buffer.
// Reset clears all control state; no run is open, nothing pending.
// When the receiver stalls, the output buffer fills, the back end halts,
// the queue fills and in_stall rises; no word is lost.
// Offsets saturate at 65536 and offset_overflow stays set for the text.
module utf8_emoji_run_segmenter import uers_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic     f_valid, f_stall;
	cp_word_t f_word;
	logic     b_valid, b_take;
	cp_word_t b_word;

	// hold decoded bytes in the front register until the queue has room
	uers_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.q_valid(f_valid), .q_stall(f_stall), .q_word(f_word)
	);

	uers_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_word(f_word),
		.rd_valid(b_valid), .rd_take(b_take), .rd_word(b_word)
	);

	uers_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_take(b_take), .q_word(b_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

endmodule

FILE: hdl/uers_checker.sv
module uers_checker import uers_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.run_start <= out_word.run_end)
		else $error("run start past end");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.run_end <= PosRep)
		else $error("run end not saturated");

	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid in reset");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_stall, out_valid}))
		else $error("handshake unknown");

endmodule

bind utf8_emoji_run_segmenter uers_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);

FILE: tb/utf8_emoji_run_segmenter_tb.sv
`timescale 1ns / 1ps

module utf8_emoji_run_segmenter_tb;
	import uers_pkg::*;

	// codepoints that steer the keycap lookahead and the run merging
	localparam int unsigned CP_JOINER   = 32'h200D;
	localparam int unsigned CP_SELECTOR = 32'hFE0F;
	localparam int unsigned CP_ENCLOSE  = 32'h20E3;
	localparam int unsigned CP_TONE_LO  = 32'h1F3FB;
	localparam int unsigned CP_TONE_HI  = 32'h1F3FF;
	localparam int unsigned POS_SAT     = MaxTextBytes + 1;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// keycap lookahead stages
	typedef enum int unsigned {KC_IDLE, KC_LEAD, KC_SELECTOR} kc_stage_t;

	typedef struct packed {
		in_word_t word;
		logic     drain;
	} byte_job_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	utf8_emoji_run_segmenter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	byte_job_t   byte_jobs[$];
	out_word_t   runs_due[$];
	logic [7:0]  text_buf[$];
	int unsigned errs = 0;
	int unsigned bytes_taken = 0;
	int unsigned cycles = 0;
	bit          byte_taken = 1'b0;

	// ---------------------------------------------------------------------
	// Run predictor: decoder state, open run and keycap lookahead
	// ---------------------------------------------------------------------
	int unsigned dec_acc, dec_need, held_n, lead_at, pos;
	int unsigned held[3];
	int unsigned open_s, open_e, kc_lead_end, kc_sel_end;
	bit          open_emo, open_any;
	kc_stage_t   kc_stage;

	function automatic bit between(int unsigned c, int unsigned lo, int unsigned hi);
		return c >= lo && c <= hi;
	endfunction

	function automatic bit joins_cluster(int unsigned c);
		return c == CP_JOINER || between(c, 32'hFE00, 32'hFE0F) || c == CP_ENCLOSE ||
			between(c, CP_TONE_LO, CP_TONE_HI);
	endfunction

	function automatic bit starts_keycap(int unsigned c);
		return between(c, 32'h30, 32'h39) || c == 32'h2A || c == 32'h23;
	endfunction

	function automatic bit emoji_base(int unsigned c);
		return c == 32'hA9 || c == 32'hAE || c == 32'h203C || c == 32'h2049 ||
			c == 32'h2122 || c == 32'h2139 || between(c, 32'h2194, 32'h2199) ||
			between(c, 32'h21A9, 32'h21AA) || between(c, 32'h231A, 32'h231B) ||
			c == 32'h2328 || c == 32'h23CF || between(c, 32'h23E9, 32'h23FA) ||
			c == 32'h24C2 || between(c, 32'h25AA, 32'h25FE) ||
			between(c, 32'h2600, 32'h27BF) || between(c, 32'h2934, 32'h2935) ||
			between(c, 32'h2B05, 32'h2B55) || c == 32'h3030 || c == 32'h303D ||
			c == 32'h3297 || c == 32'h3299 || c == 32'h1F004 || c == 32'h1F0CF ||
			between(c, 32'h1F170, 32'h1F171) || between(c, 32'h1F17E, 32'h1F17F) ||
			c == 32'h1F18E || between(c, 32'h1F191, 32'h1F19A) ||
			between(c, 32'h1F1E0, 32'h1F1FF) || between(c, 32'h1F201, 32'h1F251) ||
			between(c, 32'h1F300, 32'h1F9FF) || between(c, 32'h1FA00, 32'h1FAFF);
	endfunction

	function automatic void clear_predictor();
		dec_acc = 0; dec_need = 0; held_n = 0; lead_at = 0; pos = 0;
		held[0] = 0; held[1] = 0; held[2] = 0;
		open_s = 0; open_e = 0; open_emo = 0; open_any = 0;
		kc_lead_end = 0; kc_sel_end = 0; kc_stage = KC_IDLE;
	endfunction

	// reported offsets saturate at the maximum text size
	function automatic void post_run(int unsigned s, int unsigned e, bit emo, bit fin);
		out_word_t w;
		w.run_start = PosW'(s > MaxTextBytes ? MaxTextBytes : s);
		w.run_end = PosW'(e > MaxTextBytes ? MaxTextBytes : e);
		w.run_is_emoji = emo;
		w.run_final = fin;
		w.offset_overflow = pos > MaxTextBytes;
		runs_due.insert(runs_due.size(), w);
	endfunction

	function automatic void merge_item(bit emo, int unsigned e);
		if (open_any && open_emo == emo) begin
			open_e = e;
			return;
		end
		if (open_any) begin
			post_run(open_s, open_e, open_emo, 1'b0);
			open_s = open_e;
		end else begin
			open_s = 0;
		end
		open_any = 1;
		open_emo = emo;
		open_e = e;
	endfunction

	// continuation: extend the open run, or open a plain one
	function automatic void extend_run(int unsigned e);
		if (!open_any) begin
			open_any = 1;
			open_s = 0;
			open_emo = 0;
		end
		open_e = e;
	endfunction

	function automatic void take_cp(int unsigned c, int unsigned e);
		if (kc_stage == KC_LEAD) begin
			if (c == CP_SELECTOR) begin
				kc_sel_end = e;
				kc_stage = KC_SELECTOR;
				return;
			end
			if (c == CP_ENCLOSE) begin
				merge_item(1'b1, e);
				kc_stage = KC_IDLE;
				return;
			end
			merge_item(1'b0, kc_lead_end);
			kc_stage = KC_IDLE;
		end else if (kc_stage == KC_SELECTOR) begin
			if (c == CP_ENCLOSE) begin
				merge_item(1'b1, e);
				kc_stage = KC_IDLE;
				return;
			end
			merge_item(1'b0, kc_lead_end);
			extend_run(kc_sel_end);
			kc_stage = KC_IDLE;
		end
		if (starts_keycap(c)) begin
			kc_lead_end = e;
			kc_stage = KC_LEAD;
		end else if (joins_cluster(c)) begin
			extend_run(e);
		end else begin
			merge_item(emoji_base(c), e);
		end
	endfunction

	// text ended inside a sequence: lead counts as itself, re-decode the rest
	function automatic void redecode_tail();
		int unsigned n, i, c, left, len, cp, e;
		n = held_n > 3 ? 3 : held_n;
		i = 0;
		while (i < n) begin
			c = held[i];
			left = n - i;
			len = 1;
			cp = c;
			if ((c & 32'hE0) == 32'hC0 && left > 1) begin
				cp = ((c & 32'h1F) << 6) | (held[i+1] & 32'h3F);
				len = 2;
			end else if ((c & 32'hF0) == 32'hE0 && left > 2) begin
				cp = ((c & 32'h0F) << 12) | ((held[i+1] & 32'h3F) << 6) | (held[i+2] & 32'h3F);
				len = 3;
			end
			i += len;
			e = lead_at + i;
			take_cp(cp, e > POS_SAT ? POS_SAT : e);
		end
	endfunction

	function automatic void predict_byte(in_word_t w);
		int unsigned b, prev, n;
		b = w.text_byte;
		prev = pos;
		pos = (pos + 1 > POS_SAT) ? POS_SAT : pos + 1;
		if (dec_need == 0) begin
			n = 0;
			if ((b & 32'hE0) == 32'hC0) begin n = 1; dec_acc = b & 32'h1F; end
			else if ((b & 32'hF0) == 32'hE0) begin n = 2; dec_acc = b & 32'h0F; end
			else if ((b & 32'hF8) == 32'hF0) begin n = 3; dec_acc = b & 32'h07; end
			if (n == 0) begin
				take_cp(b, pos);
			end else begin
				dec_need = n;
				held[0] = b;
				held_n = 1;
				lead_at = prev;
				if (w.last_byte) redecode_tail();
			end
		end else begin
			dec_acc = ((dec_acc << 6) | (b & 32'h3F)) & 32'h1FFFFF;
			if (held_n < 3) held[held_n] = b;
			held_n++;
			dec_need--;
			if (dec_need == 0) begin
				held_n = 0;
				take_cp(dec_acc, pos);
			end else if (w.last_byte) begin
				redecode_tail();
			end
		end
		if (w.last_byte) begin
			// flush: a dangling keycap lead is plain text
			if (kc_stage == KC_LEAD) begin
				merge_item(1'b0, kc_lead_end);
			end else if (kc_stage == KC_SELECTOR) begin
				merge_item(1'b0, kc_lead_end);
				extend_run(kc_sel_end);
			end
			kc_stage = KC_IDLE;
			if (open_any) post_run(open_s, open_e, open_emo, 1'b1);
			clear_predictor();
		end
	endfunction

	// ---------------------------------------------------------------------
	// Text builders
	// ---------------------------------------------------------------------
	function automatic void append_byte(logic [7:0] v);
		text_buf.insert(text_buf.size(), v);
	endfunction

	task automatic put_cp(int unsigned c);
		if (c < 32'h80) begin
			append_byte(8'(c));
		end else if (c < 32'h800) begin
			append_byte(8'(32'hC0 | (c >> 6)));
			append_byte(8'(32'h80 | (c & 32'h3F)));
		end else if (c < 32'h10000) begin
			append_byte(8'(32'hE0 | (c >> 12)));
			append_byte(8'(32'h80 | ((c >> 6) & 32'h3F)));
			append_byte(8'(32'h80 | (c & 32'h3F)));
		end else begin
			append_byte(8'(32'hF0 | ((c >> 18) & 32'h07)));
			append_byte(8'(32'h80 | ((c >> 12) & 32'h3F)));
			append_byte(8'(32'h80 | ((c >> 6) & 32'h3F)));
			append_byte(8'(32'h80 | (c & 32'h3F)));
		end
	endtask

	// hand the text to the driver, last byte flagged
	task automatic close_text(bit drain);
		byte_job_t j;
		foreach (text_buf[i]) begin
			j.word.text_byte = text_buf[i];
			j.word.last_byte = (i == text_buf.size() - 1);
			j.drain = drain && i == 0;
			byte_jobs.insert(byte_jobs.size(), j);
		end
		text_buf.delete();
	endtask

	function automatic int unsigned pick_keycap_lead();
		int unsigned r;
		r = $urandom_range(0, 11);
		return r < 10 ? 32'h30 + r : (r == 10 ? 32'h2A : 32'h23);
	endfunction

	function automatic int unsigned pick_base();
		case ($urandom_range(0, 5))
			0: return $urandom_range(32'h1F300, 32'h1F9FF);
			1: return $urandom_range(32'h2600, 32'h27BF);
			2: return $urandom_range(32'h1F1E0, 32'h1F1FF);
			3: return $urandom_range(32'h1FA00, 32'h1FAFF);
			4: return $urandom_range(0, 1) ? 32'hA9 : 32'hAE;
			default: return $urandom_range(32'h2B05, 32'h2B55);
		endcase
	endfunction

	task automatic put_random_piece();
		case ($urandom_range(0, 11))
			0, 1: put_cp($urandom_range(32'h20, 32'h7E));
			2, 3: begin
				// keycap, sometimes broken
				put_cp(pick_keycap_lead());
				if ($urandom_range(0, 1)) put_cp(CP_SELECTOR);
				if ($urandom_range(0, 3) != 0) put_cp(CP_ENCLOSE);
			end
			4, 5: put_cp(pick_base());
			6: put_cp($urandom_range(0, 1) ? CP_JOINER : $urandom_range(CP_TONE_LO, CP_TONE_HI));
			7: put_cp($urandom_range(0, 1) ? CP_SELECTOR : $urandom_range(32'hFE00, 32'hFE0F));
			8: put_cp($urandom_range(32'h80, 32'hFFFF));
			9: put_cp($urandom_range(32'h10000, 32'h1FFFFF));
			10: put_cp(CP_ENCLOSE);
			default: append_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// lead byte left without all of its continuation bytes
	task automatic put_cut_tail();
		int unsigned k, n;
		k = $urandom_range(1, 3);
		case (k)
			1: append_byte(8'($urandom_range(32'hC0, 32'hDF)));
			2: append_byte(8'($urandom_range(32'hE0, 32'hEF)));
			default: append_byte(8'($urandom_range(32'hF0, 32'hF7)));
		endcase
		n = $urandom_range(0, k - 1);
		repeat (n) append_byte(8'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		int unsigned total, n;
		clear_predictor();

		// directed: keycaps with and without selector, broken keycaps
		put_cp(32'h31); put_cp(CP_ENCLOSE); close_text(0);
		put_cp(32'h23); put_cp(CP_SELECTOR); put_cp(CP_ENCLOSE); put_cp(32'h61); close_text(0);
		put_cp(32'h2A); put_cp(CP_SELECTOR); put_cp(32'h78); close_text(0);
		put_cp(32'h39); close_text(0);
		put_cp(32'h30); put_cp(CP_SELECTOR); close_text(0);
		// continuation with no run open, tones, joiners, base table edges
		put_cp(CP_JOINER); put_cp(32'h1F600); put_cp(CP_TONE_LO); put_cp(CP_TONE_HI);
		put_cp(32'h41); close_text(0);
		put_cp(32'hA9); put_cp(32'h27BF); put_cp(32'h1FAFF); put_cp(32'h1F1E0); close_text(0);
		// bad lead bytes, then cut-off sequences of each length
		append_byte(8'h80); append_byte(8'hFF); append_byte(8'h00);
		close_text(0);
		append_byte(8'h7F); append_byte(8'hC3); close_text(0);
		append_byte(8'hE2); append_byte(8'h82); close_text(0);
		append_byte(8'hF0); append_byte(8'hC3); append_byte(8'hA9);
		close_text(1);

		// random texts: mostly well formed, some noise and cut tails
		total = 0;
		while (total < 390) begin
			n = $urandom_range(1, 10);
			if ($urandom_range(0, 4) == 0) begin
				repeat (n) append_byte(8'($urandom_range(0, 255)));
			end else begin
				repeat (n) put_random_piece();
			end
			if ($urandom_range(0, 3) == 0) put_cut_tail();
			total += text_buf.size();
			close_text($urandom_range(0, 19) == 0);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (byte_jobs.size() != 0 || in_valid || runs_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errs == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// random idle length: mostly short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------------
	// Driver: advance on acceptance, idle between words
	// ---------------------------------------------------------------------
	int unsigned src_gap = 0, src_calm = 0;
	bit          src_steady = 0;

	always @(negedge clk) begin
		logic      nxt_valid;
		in_word_t  nxt_word;
		nxt_valid = in_valid;
		nxt_word = in_word;
		if (arst_n && (!in_valid || byte_taken)) begin
			nxt_valid = 1'b0;
			if (src_calm == 0) begin
				src_calm = $urandom_range(20, 80);
				src_steady = $urandom_range(0, 9) < 3;
			end else begin
				src_calm--;
			end
			if (src_gap != 0) begin
				src_gap--;
			end else if (byte_jobs.size() != 0 &&
					!(byte_jobs[0].drain && runs_due.size() != 0)) begin
				// a drain mark holds the text until all runs have come out
				nxt_word = byte_jobs[0].word;
				byte_jobs[0].drain = 1'b0;
				void'(byte_jobs.pop_front());
				nxt_valid = 1'b1;
				src_gap = src_steady ? 0 : pick_gap();
			end
		end
		byte_taken = 1'b0;
		in_valid <= nxt_valid;
		in_word <= nxt_word;
	end

	// ---------------------------------------------------------------------
	// Receiver stall: random, plus one long hold-off to back the block up
	// ---------------------------------------------------------------------
	int unsigned sink_gap = 0, sink_calm = 0, hold_left = 0;
	bit          sink_steady = 0, hold_done = 0;

	always @(negedge clk) begin
		logic nxt_stall;
		nxt_stall = 1'b0;
		if (!hold_done && bytes_taken >= 150) begin
			hold_done = 1;
			hold_left = 400;
		end
		if (sink_calm == 0) begin
			sink_calm = $urandom_range(20, 80);
			sink_steady = $urandom_range(0, 9) < 3;
		end else begin
			sink_calm--;
		end
		if (hold_left != 0) begin
			hold_left--;
			nxt_stall = 1'b1;
		end else if (sink_gap != 0) begin
			sink_gap--;
			nxt_stall = 1'b1;
		end else if (!sink_steady) begin
			sink_gap = pick_gap();
			nxt_stall = sink_gap != 0;
		end
		out_stall <= nxt_stall;
	end

	// ---------------------------------------------------------------------
	// Monitor: predict on each accepted byte, check each run word
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && in_valid && !in_stall) begin
			predict_byte(in_word);
			bytes_taken++;
			byte_taken = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (runs_due.size() == 0) begin
				$error("unexpected run word %p", out_word);
				errs++;
			end else begin
				want = runs_due.pop_front();
				if (out_word.run_start !== want.run_start) begin
					$error("run_start: expected %0d, got %0d", want.run_start, out_word.run_start);
					errs++;
				end
				if (out_word.run_end !== want.run_end) begin
					$error("run_end: expected %0d, got %0d", want.run_end, out_word.run_end);
					errs++;
				end
				if (out_word.run_is_emoji !== want.run_is_emoji) begin
					$error("run_is_emoji: expected %0b, got %0b", want.run_is_emoji,
						out_word.run_is_emoji);
					errs++;
				end
				if (out_word.run_final !== want.run_final) begin
					$error("run_final: expected %0b, got %0b", want.run_final, out_word.run_final);
					errs++;
				end
				if (out_word.offset_overflow !== want.offset_overflow) begin
					$error("offset_overflow: expected %0b, got %0b", want.offset_overflow,
						out_word.offset_overflow);
					errs++;
				end
			end
		end
	end

endmodule

FILE: files.f
hdl/uers_pkg.sv
hdl/uers_front.sv
hdl/uers_fifo.sv
hdl/uers_back.sv
hdl/utf8_emoji_run_segmenter.sv
hdl/uers_checker.sv
tb/utf8_emoji_run_segmenter_tb.sv
